// ===== rtl/sac_pkg.sv =====
// Shared types and constants for the set-associative cache tag controller.
package sac_pkg;

  localparam int unsigned NumSets  = 256;
  localparam int unsigned NumWays  = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned SetW     = $clog2(NumSets);
  localparam int unsigned WayW     = $clog2(NumWays);
  localparam int unsigned WaysCfgW = 4;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  // Ways in use right after reset; sets the rank pattern of untouched sets.
  localparam int unsigned ResetWays = 4;

  typedef enum logic [2:0] {
    REG_OFFSET_BITS   = 3'd0,
    REG_SET_BITS      = 3'd1,
    REG_WAYS_IN_USE   = 3'd2,
    REG_LFU_MODE      = 3'd3,
    REG_WRITE_THROUGH = 3'd4
  } sac_reg_e;

  // One memory row holds a whole set.
  typedef struct packed {
    logic [NumWays-1:0][AddrW-1:0] tag;
    logic [NumWays-1:0]            vld;
    logic [NumWays-1:0]            dty;
    logic [NumWays-1:0][CntW-1:0]  cnt;
    logic [CntW-1:0]               base;
  } sac_row_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

  // Contents of a set that has never been written since reset.
  function automatic sac_row_t reset_row();
    sac_row_t r;
    r = '0;
    for (int w = 0; w < NumWays; w++) begin
      if (w < ResetWays) begin
        r.cnt[w] = CntW'(ResetWays - 1 - w);
      end
    end
    reset_row = r;
  endfunction

endpackage

// ===== rtl/set_assoc_cache_lru_lfu.sv =====
// Top level of the set-associative cache tag controller (LRU/LFU, WB/WT).
//
//  channel | direction | handshake                  | payload
//  in      | input     | in_valid_i / in_stall_o    | req_type_i, address_i
//  out     | output    | out_valid_o / out_stall_i  | hit_o, way_o, allocated_o,
//          |           |                            | writeback_o, victim_tag_o
//  cfg     | input     | APB psel/penable/pready    | paddr, pwdata, prdata
//
// The accept edge reads the set's row from the set memory into a register;
// in the ST_RD state the updated row is written back and the result register
// is loaded. The set memory has a single port, so read and write-back use separate states.
// Reset clears no memory rows, only per-set row-valid flops; a set never written reads as
// empty with reset LRU ranks, so no clearing pass is needed.
// A stalled result holds the block: a new transaction is taken only once the
// result register is free or is being drained at the same edge.
module set_assoc_cache_lru_lfu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [2:0]  way_o,
  output logic        allocated_o,
  output logic        writeback_o,
  output logic [31:0] victim_tag_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NW   = sac_pkg::NumWays;
  localparam int unsigned AW   = sac_pkg::AddrW;
  localparam int unsigned CW   = sac_pkg::CntW;
  localparam int unsigned SW   = sac_pkg::SetW;
  localparam int unsigned WW   = sac_pkg::WayW;
  localparam int unsigned WCW  = sac_pkg::WaysCfgW;

  typedef enum logic {ST_IDLE, ST_RD} state_e;

  // ---------------- configuration registers ----------------
  logic [2:0]     offset_bits_q;
  logic [3:0]     set_bits_q;
  logic [WCW-1:0] ways_in_use_q;
  logic           lfu_mode_q;
  logic           write_through_q;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q   <= 3'd5;
      set_bits_q      <= 4'd8;
      ways_in_use_q   <= WCW'(sac_pkg::ResetWays);
      lfu_mode_q      <= 1'b0;
      write_through_q <= 1'b0;
    end else if (cfg_wr) begin
      case (sac_pkg::sac_reg_e'(paddr[4:2]))
        sac_pkg::REG_OFFSET_BITS:   offset_bits_q   <= pwdata[2:0];
        sac_pkg::REG_SET_BITS:      set_bits_q      <= pwdata[3:0];
        sac_pkg::REG_WAYS_IN_USE:   ways_in_use_q   <= pwdata[WCW-1:0];
        sac_pkg::REG_LFU_MODE:      lfu_mode_q      <= pwdata[0];
        sac_pkg::REG_WRITE_THROUGH: write_through_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sac_pkg::sac_reg_e'(paddr[4:2]))
      sac_pkg::REG_OFFSET_BITS:   prdata = {29'd0, offset_bits_q};
      sac_pkg::REG_SET_BITS:      prdata = {28'd0, set_bits_q};
      sac_pkg::REG_WAYS_IN_USE:   prdata = 32'(ways_in_use_q);
      sac_pkg::REG_LFU_MODE:      prdata = {31'd0, lfu_mode_q};
      sac_pkg::REG_WRITE_THROUGH: prdata = {31'd0, write_through_q};
      default:                    prdata = '0;
    endcase
  end

  // Effective ways: zero acts as one, large values clamp to NW.
  logic [WCW-1:0] nw;
  always_comb begin
    if (ways_in_use_q == '0) begin
      nw = WCW'(1);
    end else if (ways_in_use_q > WCW'(NW)) begin
      nw = WCW'(NW);
    end else begin
      nw = ways_in_use_q;
    end
  end

  // ---------------- address split ----------------
  logic [AW-1:0] addr_sh;
  logic [AW-1:0] idx_mask;
  logic [SW-1:0] set_in;
  logic [AW-1:0] tag_in;

  always_comb begin
    addr_sh  = address_i >> offset_bits_q;
    idx_mask = (AW'(1) << set_bits_q) - AW'(1);
    set_in   = SW'(addr_sh & idx_mask);
    tag_in   = address_i >> (5'(offset_bits_q) + 5'(set_bits_q));
  end

  // ---------------- control ----------------
  state_e         state_q;
  logic           accept;
  logic           out_valid_q;
  logic [SW-1:0]  set_q;
  logic [AW-1:0]  tag_q;
  logic           wr_q;

  assign in_stall_o  = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  // ---------------- set memory ----------------
  sac_pkg::sac_row_t mem [sac_pkg::NumSets];
  sac_pkg::sac_row_t rd_row_q;
  logic [sac_pkg::NumSets-1:0] row_ok_q;
  logic                        rd_ok_q;
  sac_pkg::sac_row_t cur;
  sac_pkg::sac_row_t nxt;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_row_q <= mem[set_in];
    end
    if (state_q == ST_RD) begin
      mem[set_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_ok_q <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      if (accept) begin
        rd_ok_q <= row_ok_q[set_in];
      end
      if (state_q == ST_RD) begin
        row_ok_q[set_q] <= 1'b1;
      end
    end
  end

  assign cur = rd_ok_q ? rd_row_q : sac_pkg::reset_row();

  // ---------------- lookup and update ----------------
  logic          r_hit;
  logic [WW-1:0] r_way;
  logic          r_alloc;
  logic          r_wb;
  logic [AW-1:0] r_vt;

  always_comb begin
    logic          found_hit;
    logic [WW-1:0] hw;
    logic          found_inv;
    logic [WW-1:0] iw;
    logic [WW-1:0] pos;
    logic [CW-1:0] m;
    logic [CW-1:0] r;

    nxt       = cur;
    found_hit = 1'b0;
    hw        = '0;
    found_inv = 1'b0;
    iw        = '0;
    pos       = '0;
    m         = cur.cnt[0];
    r         = '0;
    r_hit     = 1'b0;
    r_way     = '0;
    r_alloc   = 1'b0;
    r_wb      = 1'b0;
    r_vt      = '0;

    for (int j = 0; j < NW; j++) begin
      if (WCW'(j) < nw && !found_hit && cur.vld[j] && cur.tag[j] == tag_q) begin
        found_hit = 1'b1;
        hw        = WW'(j);
      end
      if (WCW'(j) < nw && !found_inv && !cur.vld[j]) begin
        found_inv = 1'b1;
        iw        = WW'(j);
      end
    end

    // Victim search over a full set, lowest way wins ties.
    for (int j = 1; j < NW; j++) begin
      if (WCW'(j) < nw) begin
        if (lfu_mode_q ? (cur.cnt[j] < m) : (cur.cnt[j] > m)) begin
          m   = cur.cnt[j];
          pos = WW'(j);
        end
      end
    end

    if (found_hit) begin
      r_hit = 1'b1;
      r_way = hw;
      if (wr_q && !write_through_q) begin
        nxt.dty[hw] = 1'b1;
      end
      if (lfu_mode_q) begin
        nxt.cnt[hw] = sac_pkg::sat_inc(cur.cnt[hw]);
      end else begin
        r = cur.cnt[hw];
        for (int j = 0; j < NW; j++) begin
          if (WCW'(j) < nw && cur.cnt[j] < r) begin
            nxt.cnt[j] = sac_pkg::sat_inc(cur.cnt[j]);
          end
        end
        nxt.cnt[hw] = '0;
      end
    end else if (!(wr_q && write_through_q)) begin
      r_alloc = 1'b1;
      if (found_inv) begin
        r_way = iw;
        if (lfu_mode_q) begin
          nxt.cnt[iw] = sac_pkg::sat_inc(cur.base);
        end else begin
          r = cur.cnt[iw];
          for (int j = 0; j < NW; j++) begin
            if (WCW'(j) < nw && cur.cnt[j] < r) begin
              nxt.cnt[j] = sac_pkg::sat_inc(cur.cnt[j]);
            end
          end
          nxt.cnt[iw] = '0;
        end
      end else begin
        r_way = pos;
        if (lfu_mode_q) begin
          nxt.base     = m;
          nxt.cnt[pos] = sac_pkg::sat_inc(m);
        end else begin
          for (int j = 0; j < NW; j++) begin
            if (WCW'(j) < nw && WW'(j) != pos) begin
              nxt.cnt[j] = sac_pkg::sat_inc(cur.cnt[j]);
            end
          end
          nxt.cnt[pos] = '0;
        end
        if (!write_through_q && cur.dty[pos]) begin
          r_wb = 1'b1;
          r_vt = cur.tag[pos];
        end
      end
      nxt.tag[r_way] = tag_q;
      nxt.vld[r_way] = 1'b1;
      nxt.dty[r_way] = wr_q;
    end
  end

  // ---------------- sequencer and result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      set_q        <= '0;
      tag_q        <= '0;
      wr_q         <= 1'b0;
      hit_o        <= 1'b0;
      way_o        <= '0;
      allocated_o  <= 1'b0;
      writeback_o  <= 1'b0;
      victim_tag_o <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            set_q   <= set_in;
            tag_q   <= tag_in;
            wr_q    <= req_type_i;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          hit_o        <= r_hit;
          way_o        <= r_way;
          allocated_o  <= r_alloc;
          writeback_o  <= r_wb;
          victim_tag_o <= r_vt;
          out_valid_q  <= 1'b1;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the set-associative cache tag controller.
`timescale 1ns / 100ps

module tb_top;

  // Expected outcome of one access
  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        allocated;
    logic        writeback;
    logic [31:0] victim_tag;
  } lookup_t;

  // Tracks the cache state and holds outcomes still due from the block
  class lookup_scoreboard;
    logic [31:0] tags [sac_pkg::NumSets][sac_pkg::NumWays];
    bit          vld  [sac_pkg::NumSets][sac_pkg::NumWays];
    bit          dty  [sac_pkg::NumSets][sac_pkg::NumWays];
    logic [15:0] cnt  [sac_pkg::NumSets][sac_pkg::NumWays];
    logic [15:0] base [sac_pkg::NumSets];
    int unsigned offset_bits, set_bits, ways_cfg;
    bit          lfu, wthru;
    lookup_t     pending[$];
    int          mismatches;

    function new();
      offset_bits = 5; set_bits = 8; ways_cfg = 4; lfu = 0; wthru = 0;
      mismatches = 0;
      for (int s = 0; s < sac_pkg::NumSets; s++) begin
        base[s] = '0;
        for (int w = 0; w < sac_pkg::NumWays; w++) begin
          tags[s][w] = '0; vld[s][w] = 0; dty[s][w] = 0;
          cnt[s][w] = (w < 4) ? 16'(3 - w) : 16'd0;
        end
      end
    endfunction

    function logic [15:0] inc(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void bump_lru(int s, int p, int nw);
      logic [15:0] r;
      r = cnt[s][p];
      for (int j = 0; j < nw; j++) if (cnt[s][j] < r) cnt[s][j] = inc(cnt[s][j]);
      cnt[s][p] = '0;
    endfunction

    // Note an accepted access and predict its outcome
    function void note_access(bit is_wr, logic [31:0] addr);
      int nw, s, hw, pos;
      logic [63:0] a64;
      logic [31:0] tag;
      logic [15:0] m;
      lookup_t e;
      nw = (ways_cfg == 0) ? 1 :
           (ways_cfg > sac_pkg::NumWays) ? sac_pkg::NumWays : ways_cfg;
      a64 = {32'd0, addr};
      s = int'((a64 >> offset_bits) & ((64'd1 << set_bits) - 1)) % sac_pkg::NumSets;
      tag = 32'(a64 >> (offset_bits + set_bits));
      e = '0; hw = -1; pos = -1;
      for (int w = 0; w < nw; w++)
        if (hw < 0 && vld[s][w] && tags[s][w] == tag) hw = w;
      if (hw >= 0) begin
        e.hit = 1; e.way = 3'(hw);
        if (is_wr && !wthru) dty[s][hw] = 1;
        if (lfu) cnt[s][hw] = inc(cnt[s][hw]);
        else bump_lru(s, hw, nw);
      end else if (!(is_wr && wthru)) begin
        for (int w = 0; w < nw; w++) if (pos < 0 && !vld[s][w]) pos = w;
        if (pos >= 0) begin
          if (lfu) cnt[s][pos] = inc(base[s]);
          else bump_lru(s, pos, nw);
        end else begin
          pos = 0; m = cnt[s][0];
          if (lfu) begin
            for (int j = 1; j < nw; j++) if (cnt[s][j] < m) begin m = cnt[s][j]; pos = j; end
            base[s] = m; cnt[s][pos] = inc(m);
          end else begin
            for (int j = 1; j < nw; j++) if (cnt[s][j] > m) begin m = cnt[s][j]; pos = j; end
            for (int j = 0; j < nw; j++) if (j != pos) cnt[s][j] = inc(cnt[s][j]);
            cnt[s][pos] = '0;
          end
          if (!wthru && dty[s][pos]) begin
            e.writeback = 1; e.victim_tag = tags[s][pos];
          end
        end
        tags[s][pos] = tag; vld[s][pos] = 1; dty[s][pos] = is_wr;
        e.allocated = 1; e.way = 3'(pos);
      end
      pending.push_back(e);
    endfunction

    function void check_result(lookup_t got);
      lookup_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: exp %p got %p", e, got);
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 400000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  logic        req_type_i = 0;
  logic [31:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  logic        hit_o, allocated_o, writeback_o;
  logic [2:0]  way_o;
  logic [31:0] victim_tag_o;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  set_assoc_cache_lru_lfu u_top (.*);

  always #5 clk_i = ~clk_i;

  lookup_scoreboard sb = new();
  int  send_idle_pct = 16;   // percent of cycles the sender holds back
  int  recv_idle_pct = 67;   // percent of cycles the receiver stalls
  int  hold_cycles   = 0;    // long receiver hold-off, counted down below
  int  cycle_count   = 0;

  // Receiver: random stall, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && rst_ni)
      sb.check_result('{hit_o, way_o, allocated_o, writeback_o, victim_tag_o});
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("set_assoc_cache_lru_lfu: mismatch");
      $finish;
    end
  end

  // One APB write; only called while the block is idle
  task automatic apb_write(sac_pkg::sac_reg_e idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      sac_pkg::REG_OFFSET_BITS:   sb.offset_bits = val & 7;
      sac_pkg::REG_SET_BITS:      sb.set_bits    = val & 15;
      sac_pkg::REG_WAYS_IN_USE:   sb.ways_cfg    = val & 15;
      sac_pkg::REG_LFU_MODE:      sb.lfu         = val[0];
      sac_pkg::REG_WRITE_THROUGH: sb.wthru       = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Offer one transaction and wait until it is taken
  task automatic send_access(bit is_wr, logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; req_type_i <= is_wr; address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_access(is_wr, addr);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(int ob, int ib, int wy, bit lf, bit wt);
    apb_write(sac_pkg::REG_OFFSET_BITS, ob);
    apb_write(sac_pkg::REG_SET_BITS, ib);
    apb_write(sac_pkg::REG_WAYS_IN_USE, wy);
    apb_write(sac_pkg::REG_LFU_MODE, lf);
    apb_write(sac_pkg::REG_WRITE_THROUGH, wt);
  endtask

  // Random address biased onto a few sets and tags so that hits,
  // evictions and dirty victims all happen often
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    if ($urandom_range(9) == 0) return $urandom();
    a = $urandom_range(3) << 6;               // few sets (any offset config)
    a = a | ($urandom_range(11) << 20);       // few tags
    a = a | ($urandom_range(63));
    return a;
  endfunction

  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: reset config, field extremes, fills, hits, dirty eviction
    send_access(0, 32'h0000_0000);
    send_access(1, 32'hFFFF_FFFF);
    send_access(1, 32'h0000_0000);
    for (int i = 0; i < 5; i++) send_access(1, 32'(i) << 13);
    send_access(0, 32'h0000_0000);
    send_access(0, 32'hAAAA_5555);
    send_access(1, 32'h5555_AAAA);
    drain();
    // Extremes: no offset/set bits, ways 0 (acts as 1), write-through
    set_mode(0, 0, 0, 0, 1);
    send_access(1, 32'h1234_5678);
    send_access(0, 32'h1234_5678);
    send_access(1, 32'h1234_5678);
    send_access(1, 32'h8765_4321);
    drain();
    // Max offset/set bits, ways above max, LFU
    set_mode(7, 8, 15, 1, 0);
    for (int i = 0; i < 10; i++) send_access(i[0], 32'(i % 9) << 15);
    drain();

    // Random phases over several settings and idle profiles
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 67; recv_idle_pct = 16; end
      if (ph == 8) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      set_mode($urandom_range(7), $urandom_range(8), $urandom_range(15),
               $urandom_range(1), (ph % 3 == 2));
      n = 130;
      for (int i = 0; i < n; i++) begin
        if (i == 40 && ph == 5) hold_cycles = 200;   // block fills and stalls input
        if (i == 80) begin
          while (sb.pending.size() != 0) begin
            in_valid_i <= 0;
            @(posedge clk_i);
          end
        end
        send_access($urandom_range(1), pick_addr());
      end
      drain();
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("set_assoc_cache_lru_lfu: match");
    else
      $display("set_assoc_cache_lru_lfu: mismatch");
    $finish;
  end
endmodule
